>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, switched off while reset is high
`define ASSERT_IMPLIES(label, ck, rs, pre, post) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, switched off while reset is high
`define ASSERT_NEXT(label, ck, rs, pre, post) \
  label: assert property (@(posedge ck) disable iff (rs) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/dgws_pkg.sv
`default_nettype none

package dgws_pkg;

  // fixed field widths
  localparam int NODE_W  = 5;
  localparam int WAVE_W  = 5;
  localparam int COUNT_W = 6;
  localparam int CFG_W   = 6;

  // hard ceiling on graph size, and default for the top level parameter
  localparam int NODE_CAP      = 32;
  localparam int MAX_NODES_DEF = 32;

  localparam logic [WAVE_W-1:0] WAVE_TOP = 5'd31;

  typedef enum logic {
    CMD_ADD_EDGE = 1'b0,
    CMD_BUILD    = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_ORDER   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_DUP   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } in_word_t;

  typedef struct packed {
    kind_t              kind;
    status_t            edge_status;
    logic [NODE_W-1:0]  node_index;
    logic [WAVE_W-1:0]  wave_level;
    logic [COUNT_W-1:0] sorted_count;
    logic [WAVE_W-1:0]  max_wave;
    logic               last;
  } out_word_t;

  // node table operations
  typedef enum logic [1:0] {
    NT_HOLD  = 2'd0,
    NT_CLEAR = 2'd1,
    NT_ACCUM = 2'd2,
    NT_RELAX = 2'd3
  } nt_op_t;

  typedef struct packed {
    nt_op_t            op;
    logic [WAVE_W-1:0] new_wave;
  } nt_cmd_t;

  typedef struct packed {
    logic              pend_zero;
    logic              now_ready;
    logic [WAVE_W-1:0] wave;
    logic [WAVE_W-1:0] wave_upd;
  } nt_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_BUILD_CLR,
    S_CNT_RD,
    S_CNT_ACC,
    S_SEED,
    S_POP,
    S_NODE,
    S_ROW_LD,
    S_SCAN,
    S_SUMMARY
  } state_t;

endpackage

`default_nettype wire

>>> hdl/dependency_graph_wave_scheduler.sv
`default_nettype none

// Dependency scheduler over up to MAX_NODES jobs (capped at 32): edges are
// loaded one word at a time into an adjacency bit matrix, and a build word
// produces a topological order of the jobs it can sort, with a wave level
// for each, then a summary word. An add-edge word returns one acknowledge
// word. A build with no jobs in use goes straight to the summary; otherwise
// the in-degree recount reads one matrix row per job in use, through a read
// state and then an accumulate state, seeding the queue tests one job per
// cycle, and the sort walks each sorted job's successor row one bit per
// cycle through the shared node-table update unit. Any output stall holds
// the block until the output register can take the waiting word.
// The block takes no new word until the last result of the current one is
// loaded into the output register; that register lets the next word come in
// while a result still waits downstream. No clearing pass follows reset: the
// matrix rows carry valid flags, and the ready queue is always written before
// it is read.

`include "assert_macros.svh"

module dependency_graph_wave_scheduler #(
  parameter int MAX_NODES = dgws_pkg::MAX_NODES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire dgws_pkg::in_word_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output dgws_pkg::out_word_t             out_data,
  input  wire logic                       cfg_we,
  input  wire logic [dgws_pkg::CFG_W-1:0] cfg_data
);
  import dgws_pkg::*;

  // storage is sized by the smaller of the parameter and the hard ceiling
  localparam int DEPTH = (MAX_NODES < NODE_CAP) ? MAX_NODES : NODE_CAP;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // configuration: number of jobs in use
  logic [CFG_W-1:0] num_nodes;
  logic [CNT_W-1:0] n;
  logic [DEPTH-1:0] mask;

  // sequencer state and counters
  state_t            state, state_next;
  logic [IDX_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  tail, tail_next;
  logic [WAVE_W-1:0] maxw, maxw_next;
  logic [WAVE_W-1:0] nw, nw_next;
  logic [DEPTH-1:0]  row_reg, row_next;
  logic [NODE_W-1:0] from_reg, to_reg;
  logic              cnt_last;

  // edge matrix ram
  logic             er_we;
  logic [IDX_W-1:0] er_raddr;
  logic [DEPTH-1:0] er_wdata;
  logic [DEPTH-1:0] er_rdata;

  // ready queue
  logic             fifo_we;
  logic [IDX_W-1:0] fifo_wdata;
  logic [IDX_W-1:0] fifo_q;

  // node table
  nt_cmd_t          nt_cmd;
  nt_stat_t         nt_stat;
  logic [IDX_W-1:0] nt_addr;

  // output register
  logic      emit;
  logic      slot_free;
  out_word_t out_next;
  status_t   edge_st;

  // config write, no handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes <= '0;
    end else if (cfg_we) begin
      num_nodes <= cfg_data;
    end
  end

  // effective job count and in-use column mask
  always_comb begin
    n = (num_nodes > CFG_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(num_nodes);
    for (int j = 0; j < DEPTH; j++) begin
      mask[j] = (CNT_W'(j) < n);
    end
  end

  assign cnt_last  = (CNT_W'(cnt) == (n - CNT_W'(1)));
  assign slot_free = !out_valid || out_ready;

  // classify an add-edge word against the row read back from the matrix
  always_comb begin
    if ((COUNT_W'(from_reg) >= COUNT_W'(n)) || (COUNT_W'(to_reg) >= COUNT_W'(n))) begin
      edge_st = ST_RANGE;
    end else if (er_rdata[to_reg[IDX_W-1:0]]) begin
      edge_st = ST_DUP;
    end else begin
      edge_st = ST_ADDED;
    end
  end

  // matrix read address follows the phase
  always_comb begin
    case (state)
      S_EDGE_RD, S_EDGE_WR: er_raddr = from_reg[IDX_W-1:0];
      S_CNT_RD, S_CNT_ACC:  er_raddr = cnt;
      default:              er_raddr = fifo_q;
    endcase
  end

  assign er_wdata = er_rdata | (DEPTH'(1) << to_reg[IDX_W-1:0]);

  // sequencer: next state, unit controls and counter updates
  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    emit            = 1'b0;
    out_next        = '0;
    er_we           = 1'b0;
    fifo_we         = 1'b0;
    fifo_wdata      = cnt;
    nt_cmd.op       = NT_HOLD;
    nt_cmd.new_wave = nw;
    nt_addr         = cnt;
    cnt_next        = cnt;
    head_next       = head;
    tail_next       = tail;
    maxw_next       = maxw;
    nw_next         = nw;
    row_next        = row_reg;

    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = (in_data.cmd == CMD_BUILD) ? S_BUILD_CLR : S_EDGE_RD;
        end
      end

      S_EDGE_RD: begin
        state_next = S_EDGE_WR;
      end

      S_EDGE_WR: begin
        if (slot_free) begin
          emit                 = 1'b1;
          out_next.kind        = KIND_ACK;
          out_next.edge_status = edge_st;
          out_next.last        = 1'b1;
          er_we                = (edge_st == ST_ADDED);
          state_next           = S_IDLE;
        end
      end

      S_BUILD_CLR: begin
        nt_cmd.op  = NT_CLEAR;
        head_next  = '0;
        tail_next  = '0;
        cnt_next   = '0;
        maxw_next  = '0;
        state_next = (n == '0) ? S_SUMMARY : S_CNT_RD;
      end

      S_CNT_RD: begin
        state_next = S_CNT_ACC;
      end

      // in-degree recount, one predecessor row at a time
      S_CNT_ACC: begin
        nt_cmd.op = NT_ACCUM;
        if (cnt_last) begin
          cnt_next   = '0;
          state_next = S_SEED;
        end else begin
          cnt_next   = cnt + IDX_W'(1);
          state_next = S_CNT_RD;
        end
      end

      // jobs with no predecessors enter the queue in index order
      S_SEED: begin
        if (nt_stat.pend_zero) begin
          fifo_we   = 1'b1;
          tail_next = tail + CNT_W'(1);
        end
        if (cnt_last) begin
          state_next = S_POP;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end

      S_POP: begin
        state_next = (head < tail) ? S_NODE : S_SUMMARY;
      end

      // emit the queue head and fetch its successor row
      S_NODE: begin
        nt_addr = fifo_q;
        if (slot_free) begin
          emit                = 1'b1;
          out_next.kind       = KIND_ORDER;
          out_next.node_index = NODE_W'(fifo_q);
          out_next.wave_level = nt_stat.wave;
          nw_next    = (nt_stat.wave == WAVE_TOP) ? WAVE_TOP : nt_stat.wave + WAVE_W'(1);
          head_next  = head + CNT_W'(1);
          state_next = S_ROW_LD;
        end
      end

      S_ROW_LD: begin
        row_next   = er_rdata & mask;
        cnt_next   = '0;
        state_next = S_SCAN;
      end

      // successor walk, one column per cycle in ascending order
      S_SCAN: begin
        if (row_reg[cnt]) begin
          nt_cmd.op = NT_RELAX;
          if (nt_stat.wave_upd > maxw) begin
            maxw_next = nt_stat.wave_upd;
          end
          if (nt_stat.now_ready && (tail < CNT_W'(DEPTH))) begin
            fifo_we   = 1'b1;
            tail_next = tail + CNT_W'(1);
          end
        end
        if (cnt_last) begin
          state_next = S_POP;
        end else begin
          cnt_next = cnt + IDX_W'(1);
        end
      end

      S_SUMMARY: begin
        if (slot_free) begin
          emit                  = 1'b1;
          out_next.kind         = KIND_SUMMARY;
          out_next.sorted_count = COUNT_W'(head);
          out_next.max_wave     = maxw;
          out_next.last         = 1'b1;
          state_next            = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      head  <= '0;
      tail  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    maxw    <= maxw_next;
    nw      <= nw_next;
    row_reg <= row_next;
    if (in_valid && in_ready) begin
      from_reg <= in_data.from_node;
      to_reg   <= in_data.to_node;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= out_next;
    end
  end

  dgws_edge_ram #(
    .DEPTH (DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (er_we),
    .waddr (from_reg[IDX_W-1:0]),
    .wdata (er_wdata),
    .raddr (er_raddr),
    .rdata (er_rdata)
  );

  dgws_ready_fifo #(
    .DEPTH (DEPTH)
  ) u_ready_fifo (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (tail[IDX_W-1:0]),
    .wdata (fifo_wdata),
    .raddr (head[IDX_W-1:0]),
    .rdata (fifo_q)
  );

  dgws_node_table #(
    .DEPTH (DEPTH)
  ) u_node_table (
    .clk  (clk),
    .cmd  (nt_cmd),
    .addr (nt_addr),
    .row  (er_rdata & mask),
    .stat (nt_stat)
  );

  // queue read pointer never passes the write pointer
  `ASSERT_IMPLIES(a_head_le_tail, clk, rst, 1'b1, head <= tail)
  // every job is queued at most once, so the queue never outgrows the job count
  `ASSERT_IMPLIES(a_tail_le_n, clk, rst, state == S_SCAN, tail <= n)
  // a taken word keeps the block busy on the next cycle
  `ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  // the summary never counts more jobs than are in use
  `ASSERT_IMPLIES(a_summary_count, clk, rst, emit && (out_next.kind == KIND_SUMMARY),
                  out_next.sorted_count <= COUNT_W'(n))

endmodule

`default_nettype wire

>>> hdl/dgws_edge_ram.sv
`default_nettype none

module dgws_edge_ram #(
  parameter int DEPTH = dgws_pkg::NODE_CAP
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [DEPTH-1:0]           wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [DEPTH-1:0]           rdata
);
  import dgws_pkg::*;

  logic [DEPTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] row_valid;
  logic [DEPTH-1:0] q;
  logic             q_valid;

  // row bits live in ram, the valid flags give the cleared-on-reset view
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      q_valid   <= 1'b0;
    end else begin
      if (we) begin
        row_valid[waddr] <= 1'b1;
      end
      q_valid <= row_valid[raddr];
    end
  end

  assign rdata = q_valid ? q : '0;

endmodule

`default_nettype wire

>>> hdl/dgws_ready_fifo.sv
`default_nettype none

module dgws_ready_fifo #(
  parameter int DEPTH = dgws_pkg::NODE_CAP
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [$clog2(DEPTH)-1:0] wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [$clog2(DEPTH)-1:0] rdata
);
  import dgws_pkg::*;

  logic [$clog2(DEPTH)-1:0] mem [DEPTH];

  // contents undefined until written, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/dgws_node_table.sv
`default_nettype none

module dgws_node_table #(
  parameter int DEPTH = dgws_pkg::NODE_CAP
) (
  input  wire logic                     clk,
  input  wire dgws_pkg::nt_cmd_t        cmd,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [DEPTH-1:0]         row,
  output dgws_pkg::nt_stat_t            stat
);
  import dgws_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]  pend [DEPTH];
  logic [WAVE_W-1:0] wave [DEPTH];
  logic [CNT_W-1:0]  p;
  logic [WAVE_W-1:0] w;

  // one shared compare / decrement unit on the addressed node
  always_comb begin
    p              = pend[addr];
    w              = wave[addr];
    stat.pend_zero = (p == '0);
    stat.now_ready = (p == CNT_W'(1));
    stat.wave      = w;
    stat.wave_upd  = (w < cmd.new_wave) ? cmd.new_wave : w;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      NT_CLEAR: begin
        for (int j = 0; j < DEPTH; j++) begin
          pend[j] <= '0;
          wave[j] <= '0;
        end
      end
      NT_ACCUM: begin
        // one predecessor row per cycle, every column counted in parallel
        for (int j = 0; j < DEPTH; j++) begin
          pend[j] <= pend[j] + CNT_W'(row[j]);
        end
      end
      NT_RELAX: begin
        wave[addr] <= stat.wave_upd;
        if (p != '0) begin
          pend[addr] <= p - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sim/tb_dependency_graph_wave_scheduler.sv
`timescale 1ns / 1ps

module tb_dependency_graph_wave_scheduler;

  import dgws_pkg::*;

  // graph size the block is built with (default parameter)
  localparam int TB_MAX_NODES = MAX_NODES_DEF;
  // generous cycle ceiling for the whole run
  localparam int CYCLE_LIMIT = 1000000;
  // long receiver hold-off, in cycles
  localparam int HOLD_CYCLES = 300;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  // pacing knobs, percent of cycles
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  // long hold-off request, raised on a falling edge, taken by the receiver
  bit hold_req = 1'b0;
  int hold_left = 0;

  // shadow of the graph plus the queue of words still owed by the block
  class wave_schedule_checker;
    logic [NODE_CAP-1:0] adj_rows [NODE_CAP];
    int unsigned live_nodes;
    out_word_t due_words[$];
    int unsigned errors;
    int unsigned checked;

    function new();
      foreach (adj_rows[i]) adj_rows[i] = '0;
      live_nodes = 0;
      errors = 0;
      checked = 0;
    endfunction

    // oversized counts clamp to the graph ceiling
    function void set_node_count(logic [CFG_W-1:0] v);
      live_nodes = v;
      if (live_nodes > TB_MAX_NODES) live_nodes = TB_MAX_NODES;
      if (live_nodes > NODE_CAP) live_nodes = NODE_CAP;
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    // works out every word an accepted input word causes
    function void note_word(in_word_t w);
      out_word_t r;
      logic [NODE_CAP-1:0] mask;
      logic [NODE_CAP-1:0] row;
      int unsigned pend [NODE_CAP];
      int unsigned wave [NODE_CAP];
      int unsigned ready_q[$];
      int unsigned n, idx, nw, sorted, maxw;
      int i, s;
      n = live_nodes;
      r = '0;
      if (w.cmd == CMD_ADD_EDGE) begin
        r.kind = KIND_ACK;
        r.last = 1'b1;
        if (w.from_node >= n || w.to_node >= n) begin
          r.edge_status = ST_RANGE;
        end else if (adj_rows[w.from_node][w.to_node]) begin
          r.edge_status = ST_DUP;
        end else begin
          adj_rows[w.from_node][w.to_node] = 1'b1;
          r.edge_status = ST_ADDED;
        end
        due_words = {due_words, r};
        return;
      end
      mask = '0;
      for (i = 0; i < n; i++) mask[i] = 1'b1;
      foreach (pend[i]) begin
        pend[i] = 0;
        wave[i] = 0;
      end
      // in-degree recount over the nodes in use
      for (i = 0; i < n; i++) begin
        row = adj_rows[i] & mask;
        for (s = 0; s < n; s++)
          if (row[s]) pend[s]++;
      end
      for (i = 0; i < n; i++)
        if (pend[i] == 0) ready_q = {ready_q, unsigned'(i)};
      sorted = 0;
      while (ready_q.size() > 0) begin
        idx = ready_q.pop_front();
        sorted++;
        r = '0;
        r.kind = KIND_ORDER;
        r.node_index = NODE_W'(idx);
        r.wave_level = WAVE_W'(wave[idx]);
        due_words = {due_words, r};
        nw = (wave[idx] < WAVE_TOP) ? wave[idx] + 1 : WAVE_TOP;
        row = adj_rows[idx] & mask;
        for (s = 0; s < n; s++) begin
          if (row[s]) begin
            if (wave[s] < nw) wave[s] = nw;
            if (pend[s] > 0) begin
              pend[s]--;
              if (pend[s] == 0) ready_q = {ready_q, unsigned'(s)};
            end
          end
        end
      end
      // nodes stuck on a cycle still count toward the deepest wave
      maxw = 0;
      for (i = 0; i < n; i++)
        if (wave[i] > maxw) maxw = wave[i];
      r = '0;
      r.kind = KIND_SUMMARY;
      r.sorted_count = COUNT_W'(sorted);
      r.max_wave = WAVE_W'(maxw);
      r.last = 1'b1;
      due_words = {due_words, r};
    endfunction

    task check_word(out_word_t got);
      out_word_t exp_w;
      string diffs;
      if (due_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got));
        return;
      end
      exp_w = due_words.pop_front();
      diffs = "";
      if (got.kind !== exp_w.kind)
        diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, exp_w.kind)};
      if (got.edge_status !== exp_w.edge_status)
        diffs = {diffs, $sformatf(" status %0d/%0d", got.edge_status, exp_w.edge_status)};
      if (got.node_index !== exp_w.node_index)
        diffs = {diffs, $sformatf(" node %0d/%0d", got.node_index, exp_w.node_index)};
      if (got.wave_level !== exp_w.wave_level)
        diffs = {diffs, $sformatf(" wave %0d/%0d", got.wave_level, exp_w.wave_level)};
      if (got.sorted_count !== exp_w.sorted_count)
        diffs = {diffs, $sformatf(" count %0d/%0d", got.sorted_count, exp_w.sorted_count)};
      if (got.max_wave !== exp_w.max_wave)
        diffs = {diffs, $sformatf(" max_wave %0d/%0d", got.max_wave, exp_w.max_wave)};
      if (got.last !== exp_w.last)
        diffs = {diffs, $sformatf(" last %0d/%0d", got.last, exp_w.last)};
      if (diffs != "") report_mismatch($sformatf("word %0d (got/exp):%s", checked, diffs));
      checked++;
    endtask
  endclass

  wave_schedule_checker sched_chk = new();

  dependency_graph_wave_scheduler uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_dependency_graph_wave_scheduler: FAIL");
    $finish;
  end

  // both handshakes sampled on the rising edge, before the edge's updates land
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sched_chk.note_word(in_data);
      if (out_valid && out_ready) sched_chk.check_word(out_data);
    end
  end

  // receiver: random stalls, or a long hold-off when asked for one
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // offer one word and hold it until taken; an idle gap may follow, and
  // with no gap valid simply stays high for the next word
  task automatic send_word(cmd_t c, int unsigned f, int unsigned t);
    in_word_t w;
    int g;
    w.cmd = c;
    w.from_node = NODE_W'(f);
    w.to_node = NODE_W'(t);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    g = 0;
    while ($urandom_range(99) < idle_pct && g < 40) g++;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic stop_sending;
    in_valid <= 1'b0;
  endtask

  // polled on the falling edge so the monitor has settled; ends on a rising edge
  task automatic wait_drained;
    do @(negedge clk); while (sched_chk.due_words.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // register writes only once the block has gone quiet
  task automatic write_node_count(int unsigned v);
    stop_sending();
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= CFG_W'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    sched_chk.set_node_count(CFG_W'(v));
  endtask

  task automatic set_pace(int unsigned send_idle, int unsigned recv_stall);
    @(negedge clk);
    idle_pct = send_idle;
    stall_pct = recv_stall;
    @(posedge clk);
  endtask

  initial begin
    int unsigned rnd_sent, phase, cfg_v, nn, a, b, k, j;
    int unsigned pace_idle [4];
    int unsigned pace_stall [4];
    pace_idle = '{0, 70, 0, 16};
    pace_stall = '{0, 0, 70, 16};
    rnd_sent = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part ---
    // empty graph: build gives the summary alone, every edge is out of range
    write_node_count(0);
    send_word(CMD_BUILD, $urandom_range(31), $urandom_range(31));
    send_word(CMD_ADD_EDGE, 0, 0);
    send_word(CMD_ADD_EDGE, 31, 31);

    // oversized count acts as the full 32 nodes
    write_node_count(63);
    send_word(CMD_ADD_EDGE, 0, 31);
    send_word(CMD_ADD_EDGE, 0, 31);   // duplicate
    send_word(CMD_ADD_EDGE, 31, 31);  // self edge, node never ready
    send_word(CMD_ADD_EDGE, 29, 30);  // two-node loop
    send_word(CMD_ADD_EDGE, 30, 29);
    send_word(CMD_ADD_EDGE, 28, 29);  // feeds a wave into the loop
    send_word(CMD_ADD_EDGE, 1, 2);
    send_word(CMD_ADD_EDGE, 2, 3);
    send_word(CMD_BUILD, $urandom_range(31), $urandom_range(31));

    // shrunk count: high edges stay stored but drop out of the build
    write_node_count(4);
    send_word(CMD_ADD_EDGE, 0, 3);
    send_word(CMD_ADD_EDGE, 31, 0);
    send_word(CMD_ADD_EDGE, 0, 4);
    send_word(CMD_ADD_EDGE, 2, 3);
    send_word(CMD_BUILD, $urandom_range(31), $urandom_range(31));

    write_node_count(32);
    send_word(CMD_BUILD, $urandom_range(31), $urandom_range(31));

    // back-pressure: receiver holds off while words keep coming, so the
    // output register fills and the block refuses input for a while
    @(negedge clk);
    hold_req = 1'b1;
    @(posedge clk);
    for (j = 0; j < 6; j++) begin
      a = $urandom_range(0, 20);
      send_word(CMD_ADD_EDGE, a, $urandom_range(a + 1, 27));
    end
    send_word(CMD_BUILD, $urandom_range(31), $urandom_range(31));
    // sender waits for every owed word before going on
    stop_sending();
    wait_drained();

    // --- random part, one pacing profile per phase ---
    for (phase = 0; phase < 4; phase++) begin
      set_pace(pace_idle[phase], pace_stall[phase]);
      while (rnd_sent < 18 * (phase + 1)) begin
        case ($urandom_range(9))
          0: cfg_v = 32;
          1: cfg_v = $urandom_range(33, 63);
          2: cfg_v = $urandom_range(16, 31);
          3: cfg_v = $urandom_range(0, 1);
          default: cfg_v = $urandom_range(2, 10);
        endcase
        write_node_count(cfg_v);
        nn = (cfg_v > NODE_CAP) ? NODE_CAP : cfg_v;

        if (nn >= 2 && $urandom_range(7) == 0) begin
          // chain of consecutive nodes for deep waves
          a = $urandom_range(0, nn - 2);
          k = $urandom_range(2, 8);
          for (j = 0; j < k && a + 1 < nn; j++) begin
            send_word(CMD_ADD_EDGE, a, a + 1);
            a++;
            rnd_sent++;
          end
        end else begin
          k = $urandom_range(2, 8);
          for (j = 0; j < k; j++) begin
            if (nn >= 2 && $urandom_range(99) < 75) begin
              // forward edge keeps the low nodes acyclic
              a = $urandom_range(0, nn - 2);
              b = $urandom_range(a + 1, nn - 1);
            end else if (nn < NODE_CAP) begin
              // out of range on one side or the other
              if ($urandom_range(1)) begin
                a = $urandom_range(nn, 31);
                b = $urandom_range(0, 31);
              end else begin
                a = $urandom_range(0, 31);
                b = $urandom_range(nn, 31);
              end
            end else begin
              // loops and self edges confined to the top nodes
              a = $urandom_range(24, 31);
              b = $urandom_range(24, 31);
            end
            send_word(CMD_ADD_EDGE, a, b);
            rnd_sent++;
          end
        end

        if ($urandom_range(99) < 85) begin
          send_word(CMD_BUILD, $urandom_range(31), $urandom_range(31));
          rnd_sent++;
        end
      end
    end

    // wind down: everything owed must arrive, then nothing more may appear
    stop_sending();
    wait_drained();
    repeat (100) @(posedge clk);
    if (sched_chk.errors == 0 && sched_chk.due_words.size() == 0) begin
      $display("tb_dependency_graph_wave_scheduler: PASS");
    end else begin
      $display("tb_dependency_graph_wave_scheduler: FAIL");
    end
    $finish;
  end

endmodule
